[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a condition at every clock edge outside reset.
`define RMQ_ASSERT(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("rmq assertion failed");
// Checks that a trigger implies a consequence at the same edge.
`define RMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rmq implication failed");
`else
`define RMQ_ASSERT(lbl, clk, rstn, cond)
`define RMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/rmq_pkg.sv]
package rmq_pkg;

  // Default number of fraction bits in the fixed-point format.
  localparam int FRAC_BITS_DEF = 14;

  // Input transaction: the nine matrix entries, row major.
  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  // Result transaction: the quaternion.
  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } out_t;

  // Which component comes from the square root.
  typedef enum logic [1:0] {
    BR_W = 2'd0,
    BR_X = 2'd1,
    BR_Y = 2'd2,
    BR_Z = 2'd3
  } br_t;

  // Classified work passed from the front end to the back end.
  typedef struct packed {
    br_t              br;
    logic [2:0]       neg;
    logic [2:0][16:0] mag;
  } num_t;

  // Width of the unsigned square root argument.
  function automatic int arg_w(int frac);
    return ((frac > 17) ? frac : 17) + 2;
  endfunction

endpackage

[design/rmq_front.sv]
`include "assert_macros.svh"
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  in_t                             in_data,
  output logic                            q_valid,
  input  logic                            q_stall,
  output logic [arg_w(FRAC_BITS)-1:0]     q_arg,
  output num_t                            q_num
);

  localparam int AW  = arg_w(FRAC_BITS);
  localparam int AWS = AW + 1;
  localparam logic signed [AWS-1:0] ONE_S = AWS'(1) << FRAC_BITS;

  logic                   f_v_r;
  logic [AW-1:0]          f_arg_r, f_arg_nxt;
  num_t                   f_num_r, f_num_nxt;
  logic signed [17:0]     trace;
  logic signed [AWS-1:0]  arg_s;
  logic signed [16:0]     d_21_12, d_02_20, d_10_01, s_01_10, s_02_20, s_12_21;
  logic signed [16:0]     n0, n1, n2;

  assign in_stall = f_v_r && q_stall;
  assign q_valid  = f_v_r;
  assign q_arg    = f_arg_r;
  assign q_num    = f_num_r;

  // Trace and the six off-diagonal combinations.
  always_comb begin
    trace   = 18'(in_data.m00) + 18'(in_data.m11) + 18'(in_data.m22);
    d_21_12 = 17'(in_data.m21) - 17'(in_data.m12);
    d_02_20 = 17'(in_data.m02) - 17'(in_data.m20);
    d_10_01 = 17'(in_data.m10) - 17'(in_data.m01);
    s_01_10 = 17'(in_data.m01) + 17'(in_data.m10);
    s_02_20 = 17'(in_data.m02) + 17'(in_data.m20);
    s_12_21 = 17'(in_data.m12) + 17'(in_data.m21);
  end

  // Branch choice, square root argument and numerator selection.
  always_comb begin
    if (trace > 18'sd0) begin
      f_num_nxt.br = BR_W;
      arg_s = ONE_S + AWS'(trace);
      n0 = d_21_12; n1 = d_02_20; n2 = d_10_01;
    end else if (in_data.m00 > in_data.m11 && in_data.m00 > in_data.m22) begin
      f_num_nxt.br = BR_X;
      arg_s = ONE_S + AWS'(in_data.m00) - AWS'(in_data.m11) - AWS'(in_data.m22);
      n0 = d_21_12; n1 = s_01_10; n2 = s_02_20;
    end else if (in_data.m11 > in_data.m22) begin
      f_num_nxt.br = BR_Y;
      arg_s = ONE_S + AWS'(in_data.m11) - AWS'(in_data.m00) - AWS'(in_data.m22);
      n0 = d_02_20; n1 = s_01_10; n2 = s_12_21;
    end else begin
      f_num_nxt.br = BR_Z;
      arg_s = ONE_S + AWS'(in_data.m22) - AWS'(in_data.m00) - AWS'(in_data.m11);
      n0 = d_10_01; n1 = s_02_20; n2 = s_12_21;
    end
    f_arg_nxt        = arg_s[AW-1:0];
    f_num_nxt.neg    = {n2[16], n1[16], n0[16]};
    f_num_nxt.mag[0] = n0[16] ? 17'(-n0) : 17'(n0);
    f_num_nxt.mag[1] = n1[16] ? 17'(-n1) : 17'(n1);
    f_num_nxt.mag[2] = n2[16] ? 17'(-n2) : 17'(n2);
  end

  // Front register: loads whenever it is empty or drains into the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (!in_stall) begin
      f_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      f_arg_r <= f_arg_nxt;
      f_num_r <= f_num_nxt;
    end
  end

  // The square root argument is positive in every branch.
  `RMQ_ASSERT_IMP(a_arg_pos, clk, rst_n, f_v_r, f_arg_r != '0)

endmodule

[design/rmq_fifo.sv]
`include "assert_macros.svh"
module rmq_fifo #(
  parameter int WD = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [WD-1:0] in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [WD-1:0] out_data
);

  logic [WD-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;

  assign in_stall  = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rp_r];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // Occupancy update.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  // Occupancy never exceeds the two entries.
  `RMQ_ASSERT(a_cnt_max, clk, rst_n, cnt_r != 2'd3)

endmodule

[design/rmq_div.sv]
module rmq_div #(
  parameter int DVW = 33,
  parameter int DSW = 20
) (
  input  logic           clk,
  input  logic           en,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic [DVW-1:0] quotient
);

  // One restoring step per stage, one quotient bit per stage.
  logic [DVW-1:0] dvd_r [DVW];
  logic [DVW-1:0] quo_r [DVW];
  logic [DSW-1:0] rem_r [DVW];
  logic [DSW-1:0] dsr_r [DVW];

  for (genvar j = 0; j < DVW; j++) begin : g_stage
    logic [DVW-1:0] dvd_in, quo_in;
    logic [DSW-1:0] rem_in, dsr_in;
    logic [DSW:0]   cat, diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign dvd_in = dividend;
      assign quo_in = '0;
      assign rem_in = '0;
      assign dsr_in = divisor;
    end else begin : g_next
      assign dvd_in = dvd_r[j-1];
      assign quo_in = quo_r[j-1];
      assign rem_in = rem_r[j-1];
      assign dsr_in = dsr_r[j-1];
    end

    assign cat  = {rem_in, dvd_in[DVW-1]};
    assign ge   = cat >= {1'b0, dsr_in};
    assign diff = cat - {1'b0, dsr_in};

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[j] <= dvd_in << 1;
        quo_r[j] <= {quo_in[DVW-2:0], ge};
        rem_r[j] <= ge ? diff[DSW-1:0] : cat[DSW-1:0];
        dsr_r[j] <= dsr_in;
      end
    end
  end

  assign quotient = quo_r[DVW-1];

endmodule

[design/rmq_back.sv]
`include "assert_macros.svh"
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [arg_w(FRAC_BITS)-1:0] in_arg,
  input  num_t                        in_num,
  output logic                        out_valid,
  input  logic                        out_stall,
  output out_t                        out_data
);

  localparam int AW  = arg_w(FRAC_BITS);
  localparam int VW0 = AW + FRAC_BITS;
  localparam int VWE = VW0 + (VW0 % 2);
  localparam int NS  = VWE / 2;
  localparam int RMW = NS + 2;
  localparam int RW  = NS + 1;
  localparam int DSW = RW + 2;
  localparam int DVW = FRAC_BITS + 19;
  localparam int LIM = ((1 << FRAC_BITS) < 32767) ? (1 << FRAC_BITS) : 32767;

  logic en;

  // Square root pipeline registers, two radicand bits per stage.
  logic           sq_v_r    [NS];
  logic [VWE-1:0] sq_rad_r  [NS];
  logic [RMW-1:0] sq_rem_r  [NS];
  logic [NS-1:0]  sq_root_r [NS];
  num_t           sq_num_r  [NS];

  // Rounding stage registers.
  logic           rd_v_r;
  logic [DVW-1:0] rd_dvd_r [3];
  logic [DSW-1:0] rd_dsr_r;
  logic [RW-1:0]  rd_bc_r;
  logic [2:0]     rd_neg_r;
  br_t            rd_br_r;

  // Side information that travels alongside the dividers.
  logic           dt_v_r   [DVW];
  logic [RW-1:0]  dt_bc_r  [DVW];
  logic [2:0]     dt_neg_r [DVW];
  br_t            dt_br_r  [DVW];

  logic           out_v_r;
  out_t           out_d_r, out_d_nxt;
  logic [DVW-1:0] quo [3];
  logic [NS-1:0]  sq_q;
  logic [RW-1:0]  rnd;
  logic [RW:0]    bc_sum;

  // The whole back end advances unless a finished result is held.
  assign en        = !(out_v_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic           v_in;
    logic [VWE-1:0] rad_in;
    logic [RMW-1:0] rem_in;
    logic [NS-1:0]  root_in;
    num_t           num_in;
    logic [RMW+1:0] cat, sub, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rad_in  = VWE'({in_arg, {FRAC_BITS{1'b0}}});
      assign rem_in  = '0;
      assign root_in = '0;
      assign num_in  = in_num;
    end else begin : g_next
      assign v_in    = sq_v_r[k-1];
      assign rad_in  = sq_rad_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign num_in  = sq_num_r[k-1];
    end

    assign cat  = {rem_in, rad_in[VWE-1 -: 2]};
    assign sub  = {2'b00, root_in, 2'b01};
    assign ge   = cat >= sub;
    assign diff = cat - sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else if (en) begin
        sq_v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[k]  <= rad_in << 2;
        sq_rem_r[k]  <= ge ? diff[RMW-1:0] : cat[RMW-1:0];
        sq_root_r[k] <= {root_in[NS-2:0], ge};
        sq_num_r[k]  <= num_in;
      end
    end
  end

  // Round the root to nearest and build divisor and dividends.
  assign sq_q   = sq_root_r[NS-1];
  assign rnd    = RW'(sq_q) + RW'(sq_rem_r[NS-1] > {2'b00, sq_q});
  assign bc_sum = {1'b0, rnd} + (RW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else if (en) begin
      rd_v_r <= sq_v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rd_dvd_r[i] <= DVW'({sq_num_r[NS-1].mag[i], {(FRAC_BITS + 1){1'b0}}})
                       + DVW'({rnd, 1'b0});
      end
      rd_dsr_r <= {rnd, 2'b00};
      rd_bc_r  <= bc_sum[RW:1];
      rd_neg_r <= sq_num_r[NS-1].neg;
      rd_br_r  <= sq_num_r[NS-1].br;
    end
  end

  // Three dividers, one per off-diagonal component.
  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div #(
      .DVW(DVW),
      .DSW(DSW)
    ) u_div (
      .clk      (clk),
      .en       (en),
      .dividend (rd_dvd_r[i]),
      .divisor  (rd_dsr_r),
      .quotient (quo[i])
    );
  end

  // Delay line matching the divider depth.
  for (genvar j = 0; j < DVW; j++) begin : g_dt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dt_v_r[j] <= 1'b0;
      end else if (en) begin
        dt_v_r[j] <= (j == 0) ? rd_v_r : dt_v_r[(j == 0) ? 0 : j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (j == 0) begin
          dt_bc_r[j]  <= rd_bc_r;
          dt_neg_r[j] <= rd_neg_r;
          dt_br_r[j]  <= rd_br_r;
        end else begin
          dt_bc_r[j]  <= dt_bc_r[(j == 0) ? 0 : j-1];
          dt_neg_r[j] <= dt_neg_r[(j == 0) ? 0 : j-1];
          dt_br_r[j]  <= dt_br_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // Saturate a quotient magnitude and apply its sign.
  function automatic logic signed [15:0] sat_q(logic [DVW-1:0] q, logic n);
    logic [15:0] m;
    m = (q > DVW'(LIM)) ? 16'(LIM) : q[15:0];
    return n ? -m : m;
  endfunction

  // Place the four components according to the branch.
  always_comb begin
    logic signed [15:0] bc, c0, c1, c2;
    bc = (dt_bc_r[DVW-1] > RW'(LIM)) ? 16'(LIM) : 16'(dt_bc_r[DVW-1]);
    c0 = sat_q(quo[0], dt_neg_r[DVW-1][0]);
    c1 = sat_q(quo[1], dt_neg_r[DVW-1][1]);
    c2 = sat_q(quo[2], dt_neg_r[DVW-1][2]);
    case (dt_br_r[DVW-1])
      BR_W: begin
        out_d_nxt = '{quat_x: c0, quat_y: c1, quat_z: c2, quat_w: bc};
      end
      BR_X: begin
        out_d_nxt = '{quat_x: bc, quat_y: c1, quat_z: c2, quat_w: c0};
      end
      BR_Y: begin
        out_d_nxt = '{quat_x: c1, quat_y: bc, quat_z: c2, quat_w: c0};
      end
      default: begin
        out_d_nxt = '{quat_x: c1, quat_y: c2, quat_z: bc, quat_w: c0};
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dt_v_r[DVW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= out_d_nxt;
    end
  end

  // The rounded root is never zero, so no divide by zero reaches the dividers.
  `RMQ_ASSERT_IMP(a_dsr_nz, clk, rst_n, rd_v_r, rd_dsr_r != '0)
  // A result appears only after a transaction left the divider delay line.
  `RMQ_ASSERT_IMP(a_out_src, clk, rst_n, $rose(out_v_r), $past(dt_v_r[DVW-1]))

endmodule

[design/rotation_matrix_to_quaternion.sv]
// Throughput: one transaction per cycle while out_stall is not held, set by the pipelined
// square root (two bits per stage) and the three pipelined dividers (one quotient bit per stage).
// Reset: synchronous, active low; clears all valid bits and the queue, no datapath reset.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = arg_w(FRAC_BITS);
  localparam int WD = AW + $bits(num_t);

  logic          fq_valid, fq_stall, qb_valid, qb_stall;
  logic [AW-1:0] fq_arg;
  num_t          fq_num;
  logic [WD-1:0] qb_data;

  // Front end: classify and form the square root argument and numerators.
  rmq_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_stall  (fq_stall),
    .q_arg    (fq_arg),
    .q_num    (fq_num)
  );

  // Decoupling queue between front and back.
  rmq_fifo #(
    .WD(WD)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_stall  (fq_stall),
    .in_data   ({fq_arg, fq_num}),
    .out_valid (qb_valid),
    .out_stall (qb_stall),
    .out_data  (qb_data)
  );

  // Back end: square root, divisions, saturation.
  rmq_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (qb_valid),
    .in_stall  (qb_stall),
    .in_arg    (qb_data[WD-1 -: AW]),
    .in_num    (qb_data[$bits(num_t)-1:0]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
